/* src/i2cseq_pkg.sv */
`timescale 1ns / 1ps
package i2cseq_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [15:0] TIMEOUT_RESET = 16'd10000;
  localparam logic [15:0] WAIT_MAX = 16'hFFFF;
  localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;
  localparam logic [7:0] BYTE_ZERO = 8'h00;

  // register index, taken from paddr[2]
  localparam logic REG_TIMEOUT = 1'b0;

  typedef enum logic [1:0] {
    MODE_REQUEST = 2'd0,
    MODE_PAYLOAD = 2'd1,
    MODE_DONE    = 2'd2,
    MODE_TICK    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OP_PING  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_BULK  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_START  = 3'd0,
    K_RSTART = 3'd1,
    K_STOP   = 3'd2,
    K_SEND   = 3'd3,
    K_RECV   = 3'd4
  } cmd_kind_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_START   = 4'd1,
    PH_ADDR_W  = 4'd2,
    PH_REG     = 4'd3,
    PH_DATA    = 4'd4,
    PH_RSTART  = 4'd5,
    PH_ADDR_R  = 4'd6,
    PH_RECV    = 4'd7,
    PH_STOP    = 4'd8,
    PH_PAYLOAD = 4'd9
  } phase_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] op;
    logic [6:0] device_id;
    logic [7:0] reg_index;
    logic [7:0] data_byte;
    logic [7:0] bulk_len;
    logic       nack_seen;
    logic [7:0] read_byte;
    logic       prim_failed;
  } in_item_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] cmd_kind;
    logic [7:0] cmd_byte;
    logic       need_data;
    logic       reply_valid;
    logic       reply_status;
    logic [7:0] reply_data;
  } out_item_t;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  current_op;
    logic [6:0]  target_addr;
    logic [7:0]  target_reg;
    logic [7:0]  single_data;
    logic [7:0]  bytes_left;
    logic [7:0]  held_result;
    logic        failed_flag;
    logic [15:0] wait_count;
  } seq_state_t;

  localparam seq_state_t STATE_RESET = '{
    phase:       PH_IDLE,
    current_op:  2'd0,
    target_addr: 7'd0,
    target_reg:  8'd0,
    single_data: 8'd0,
    bytes_left:  8'd0,
    held_result: 8'hFF,
    failed_flag: 1'b0,
    wait_count:  16'd0
  };

endpackage

/* src/i2cseq_step.sv */
`timescale 1ns / 1ps
module i2cseq_step (
  input  i2cseq_pkg::seq_state_t st,
  input  i2cseq_pkg::in_item_t   item,
  input  logic [15:0]            timeout_limit,
  output i2cseq_pkg::seq_state_t st_nxt,
  output logic                   res_vld,
  output i2cseq_pkg::out_item_t  res
);
  import i2cseq_pkg::*;

  logic        go;
  logic        failed;
  logic        nack;
  logic        bad;
  logic [7:0]  rb;
  logic [15:0] wc_inc;
  logic        cmd_go;
  cmd_kind_t   cmd_kind;
  logic [7:0]  cmd_byte;
  phase_t      cmd_phase;
  logic        ask;
  logic        rep_go;
  logic        rep_status;
  logic [7:0]  rep_data;
  logic        to_idle;
  logic [7:0]  err_data;

  assign err_data = (op_t'(st.current_op) == OP_READ) ? BYTE_ALL_ONES : BYTE_ZERO;

  always_comb begin
    st_nxt     = st;
    go         = 1'b0;
    failed     = item.prim_failed;
    nack       = item.nack_seen;
    rb         = item.read_byte;
    wc_inc     = (st.wait_count == WAIT_MAX) ? st.wait_count : st.wait_count + 16'd1;
    cmd_go     = 1'b0;
    cmd_kind   = K_START;
    cmd_byte   = BYTE_ZERO;
    cmd_phase  = PH_IDLE;
    ask        = 1'b0;
    rep_go     = 1'b0;
    rep_status = 1'b0;
    rep_data   = BYTE_ZERO;
    to_idle    = 1'b0;

    if (st.phase == PH_IDLE) begin
      if (mode_t'(item.mode) == MODE_REQUEST) begin
        st_nxt.current_op  = item.op;
        st_nxt.target_addr = item.device_id;
        st_nxt.target_reg  = item.reg_index;
        st_nxt.single_data = item.data_byte;
        st_nxt.bytes_left  = (op_t'(item.op) == OP_BULK) ? item.bulk_len : 8'd0;
        st_nxt.held_result = BYTE_ALL_ONES;
        st_nxt.failed_flag = 1'b0;
        cmd_go    = 1'b1;
        cmd_kind  = K_START;
        cmd_phase = PH_START;
      end
    end else if (mode_t'(item.mode) == MODE_REQUEST) begin
      // busy: request dropped
    end else if (st.phase == PH_PAYLOAD) begin
      if (mode_t'(item.mode) == MODE_PAYLOAD) begin
        st_nxt.bytes_left = st.bytes_left - 8'd1;
        cmd_go    = 1'b1;
        cmd_kind  = K_SEND;
        cmd_byte  = item.data_byte;
        cmd_phase = PH_DATA;
      end
    end else if (mode_t'(item.mode) == MODE_PAYLOAD) begin
      // stray payload byte
    end else if (mode_t'(item.mode) == MODE_TICK) begin
      st_nxt.wait_count = wc_inc;
      go     = (wc_inc >= timeout_limit);
      failed = 1'b1;
      nack   = 1'b0;
      rb     = BYTE_ALL_ONES;
    end else begin
      go = 1'b1;
    end

    bad = failed | nack;

    if (go) begin
      unique case (st.phase)
        PH_START: begin
          if (failed) begin
            rep_go = 1'b1; rep_status = 1'b1; rep_data = err_data;
          end else begin
            cmd_go = 1'b1; cmd_kind = K_SEND;
            cmd_byte = {st.target_addr, 1'b0}; cmd_phase = PH_ADDR_W;
          end
        end
        PH_ADDR_W: begin
          cmd_go = 1'b1;
          if (op_t'(st.current_op) == OP_PING) begin
            st_nxt.failed_flag = bad;
            cmd_kind = K_STOP; cmd_phase = PH_STOP;
          end else if (bad) begin
            st_nxt.failed_flag = 1'b1;
            cmd_kind = K_STOP; cmd_phase = PH_STOP;
          end else begin
            cmd_kind = K_SEND; cmd_byte = st.target_reg; cmd_phase = PH_REG;
          end
        end
        PH_REG: begin
          if (bad) begin
            st_nxt.failed_flag = 1'b1;
            cmd_go = 1'b1; cmd_kind = K_STOP; cmd_phase = PH_STOP;
          end else if (op_t'(st.current_op) == OP_READ) begin
            cmd_go = 1'b1; cmd_kind = K_RSTART; cmd_phase = PH_RSTART;
          end else if (op_t'(st.current_op) == OP_WRITE) begin
            cmd_go = 1'b1; cmd_kind = K_SEND;
            cmd_byte = st.single_data; cmd_phase = PH_DATA;
          end else if (st.bytes_left == 8'd0) begin
            cmd_go = 1'b1; cmd_kind = K_STOP; cmd_phase = PH_STOP;
          end else begin
            ask = 1'b1;
          end
        end
        PH_DATA: begin
          if (bad) begin
            st_nxt.failed_flag = 1'b1;
            cmd_go = 1'b1; cmd_kind = K_STOP; cmd_phase = PH_STOP;
          end else if (op_t'(st.current_op) == OP_BULK && st.bytes_left != 8'd0) begin
            ask = 1'b1;
          end else begin
            cmd_go = 1'b1; cmd_kind = K_STOP; cmd_phase = PH_STOP;
          end
        end
        PH_RSTART: begin
          cmd_go = 1'b1;
          if (failed) begin
            st_nxt.failed_flag = 1'b1;
            cmd_kind = K_STOP; cmd_phase = PH_STOP;
          end else begin
            cmd_kind = K_SEND; cmd_byte = {st.target_addr, 1'b1}; cmd_phase = PH_ADDR_R;
          end
        end
        PH_ADDR_R: begin
          cmd_go = 1'b1;
          if (bad) begin
            st_nxt.failed_flag = 1'b1;
            cmd_kind = K_STOP; cmd_phase = PH_STOP;
          end else begin
            cmd_kind = K_RECV; cmd_phase = PH_RECV;
          end
        end
        PH_RECV: begin
          if (failed) begin
            st_nxt.held_result = BYTE_ALL_ONES;
            st_nxt.failed_flag = 1'b1;
          end else begin
            st_nxt.held_result = rb;
          end
          cmd_go = 1'b1; cmd_kind = K_STOP; cmd_phase = PH_STOP;
        end
        PH_STOP: begin
          rep_go = 1'b1;
          if (op_t'(st.current_op) == OP_PING) begin
            rep_status = st.failed_flag;
          end else if (st.failed_flag) begin
            rep_status = 1'b1; rep_data = err_data;
          end else if (op_t'(st.current_op) == OP_READ) begin
            rep_data = st.held_result;
          end else begin
            rep_status = failed;
          end
        end
        default: to_idle = 1'b1;
      endcase
    end

    res_vld = cmd_go | ask | rep_go;
    res     = '0;
    if (cmd_go) begin
      st_nxt.wait_count = 16'd0;
      st_nxt.phase      = cmd_phase;
      res.cmd_valid     = 1'b1;
      res.cmd_kind      = cmd_kind;
      res.cmd_byte      = cmd_byte;
    end
    if (ask) begin
      st_nxt.phase  = PH_PAYLOAD;
      res.need_data = 1'b1;
    end
    if (rep_go) begin
      st_nxt.phase      = PH_IDLE;
      st_nxt.wait_count = 16'd0;
      res.reply_valid   = 1'b1;
      res.reply_status  = rep_status;
      res.reply_data    = rep_data;
    end
    if (to_idle) begin
      st_nxt.phase = PH_IDLE;
    end
  end

endmodule

/* src/i2c_register_transaction_sequencer.sv */
// i2c register transaction sequencer: runs ping, register write, register
// read and bulk write transactions on top of a byte-level i2c bus engine
// in channel (in_valid/in_ready/in_data): host requests, bulk payload
//   bytes, primitive-done reports from the engine and timeout ticks
// out channel (out_valid/out_ready/out_data): at most one result per input
//   transaction - a bus command, a request for the next payload byte, or the
//   final reply of the host transaction; inputs that cause nothing give none
// cfg port: apb-style, register 0 at byte address 0 is timeout_limit
//   (ticks allowed per primitive, reset 10000)
// output timing: a result is registered and appears on out_valid in the
//   cycle after its input transaction is accepted
// throughput: one input transaction per cycle while the output register is
//   free or being drained; the sequencing step is a single combinational
//   pass between the state register and the output register
// reset (rst_n low, synchronous): sequencer returns to idle, output register
//   empties, timeout_limit goes back to 10000
// receiver stall: the output register holds its result; in_ready stays high
//   while the output register is empty or is being drained that cycle
`timescale 1ns / 1ps
module i2c_register_transaction_sequencer (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  i2cseq_pkg::in_item_t                   in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output i2cseq_pkg::out_item_t                  out_data,
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [i2cseq_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [i2cseq_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [i2cseq_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                   cfg_pready
);
  import i2cseq_pkg::*;

  seq_state_t  state_r;
  seq_state_t  state_nxt;
  logic [15:0] timeout_r;
  logic [15:0] timeout_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  out_item_t   out_data_r;
  out_item_t   step_res;
  logic        step_vld;
  logic        in_fire;
  logic        cfg_wr;
  seq_state_t  step_state;

  // accept whenever the output register is free or being emptied
  assign in_ready = ~out_valid_r | out_ready;
  assign in_fire  = in_valid & in_ready;

  i2cseq_step u_step (
    .st            (state_r),
    .item          (in_data),
    .timeout_limit (timeout_r),
    .st_nxt        (step_state),
    .res_vld       (step_vld),
    .res           (step_res)
  );

  // sequencer state only moves on an accepted transaction
  assign state_nxt = in_fire ? step_state : state_r;

  always_comb begin
    if (in_fire && step_vld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // apb write of the timeout register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    timeout_nxt = timeout_r;
    if (cfg_wr && cfg_paddr[2] == REG_TIMEOUT) begin
      timeout_nxt = cfg_pwdata[15:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_TIMEOUT) begin
      cfg_prdata[15:0] = timeout_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RESET;
      timeout_r   <= TIMEOUT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      timeout_r   <= timeout_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded only when a new result is produced
  always_ff @(posedge clk) begin
    if (in_fire && step_vld) begin
      out_data_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
